// ===== rtl/affine_matrix_inverse_4x4_unit_macros.svh =====
// assertion macros for the affine matrix inverse unit
// expects signals named clock and reset in the module that uses them
`ifndef AFFINE_MATRIX_INVERSE_4X4_UNIT_MACROS_SVH
`define AFFINE_MATRIX_INVERSE_4X4_UNIT_MACROS_SVH

// same-cycle implication
`define AMI_ASSERT_IMP(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication
`define AMI_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== rtl/ami_pkg.sv =====
// types, constants and selection tables for the affine matrix inverse unit
// no dependencies
package ami_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int VALUE_WIDTH   = 32;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic signed [63:0]            wide_type;
   typedef logic [3:0]                    index_type;
   typedef logic [5:0]                    shift_type;

   localparam shift_type TOL_RESET = 6'd20;

   localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
   localparam logic [63:0] VAL_LIM = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;
   localparam logic [63:0] ONE_RAW = 64'd1 << FRACTION_BITS;
   localparam logic        ONE_SAT = (ONE_RAW > VAL_LIM);
   localparam logic [63:0] ONE_VAL = ONE_SAT ? VAL_LIM : ONE_RAW;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SETUP, ST_MUL, ST_FIN, ST_POST,
      ST_DET, ST_CHECK, ST_DIV, ST_RECIP, ST_EMIT
   } state_type;

   typedef enum logic [1:0] {PH_TRI, PH_COF, PH_TRN} phase_type;
   typedef enum logic [1:0] {SH_NONE, SH_FRAC, SH_RECIP} shsel_type;

   typedef struct packed {
      index_type a;
      index_type b;
      index_type c;
      logic      flip;
   } tri_sel_type;

   typedef struct packed {
      index_type a;
      index_type b;
      index_type c;
      index_type d;
   } cof_sel_type;

   // triple products of the 3x3 determinant, flip negates the third factor
   function automatic tri_sel_type tri_sel(input logic [2:0] k);
      tri_sel_type s;
      unique case (k)
         3'd0:    s = '{4'd0, 4'd5, 4'd10, 1'b0};
         3'd1:    s = '{4'd1, 4'd6, 4'd8,  1'b0};
         3'd2:    s = '{4'd2, 4'd4, 4'd9,  1'b0};
         3'd3:    s = '{4'd2, 4'd5, 4'd8,  1'b1};
         3'd4:    s = '{4'd1, 4'd4, 4'd10, 1'b1};
         3'd5:    s = '{4'd0, 4'd6, 4'd9,  1'b1};
         default: s = '{4'd0, 4'd0, 4'd0,  1'b0};
      endcase
      return s;
   endfunction

   // adjugate entry k = a*b - c*d
   function automatic cof_sel_type cof_sel(input logic [3:0] k);
      cof_sel_type s;
      unique case (k)
         4'd0:    s = '{4'd5, 4'd10, 4'd6, 4'd9};
         4'd1:    s = '{4'd2, 4'd9,  4'd1, 4'd10};
         4'd2:    s = '{4'd1, 4'd6,  4'd2, 4'd5};
         4'd3:    s = '{4'd6, 4'd8,  4'd4, 4'd10};
         4'd4:    s = '{4'd0, 4'd10, 4'd2, 4'd8};
         4'd5:    s = '{4'd2, 4'd4,  4'd0, 4'd6};
         4'd6:    s = '{4'd4, 4'd9,  4'd5, 4'd8};
         4'd7:    s = '{4'd1, 4'd8,  4'd0, 4'd9};
         4'd8:    s = '{4'd0, 4'd5,  4'd1, 4'd4};
         default: s = '{4'd0, 4'd0,  4'd0, 4'd0};
      endcase
      return s;
   endfunction

   // 3x3 position to 4x4 element index
   function automatic index_type cof_elem(input logic [3:0] k);
      index_type e;
      if (k >= 4'd6) begin
         e = k + 4'd2;
      end else if (k >= 4'd3) begin
         e = k + 4'd1;
      end else begin
         e = k;
      end
      return e;
   endfunction

   function automatic wide_type sx(input value_type v);
      return {{(64-VALUE_WIDTH){v[VALUE_WIDTH-1]}}, v};
   endfunction

   // saturating add, bit 64 is the clip flag
   function automatic logic [64:0] adds(input wide_type a, input wide_type b);
      logic [63:0] s;
      logic        ovf;
      s   = a + b;
      ovf = (a[63] == b[63]) && (s[63] != a[63]);
      if (ovf) begin
         return {1'b1, a[63] ? {1'b1, 63'd0} : S64_MAX};
      end
      return {1'b0, s};
   endfunction

endpackage

// ===== rtl/ami_ifs.sv =====
// handshake channels of the affine matrix inverse unit
// depends on ami_pkg
interface ami_req_if;
   logic                 valid;
   logic                 ready;
   ami_pkg::index_type   element_index;
   ami_pkg::value_type   element_value;
   logic                 last_element;
   modport source (output valid, element_index, element_value, last_element, input ready);
   modport sink   (input valid, element_index, element_value, last_element, output ready);
endinterface

interface ami_rsp_if;
   logic                 valid;
   logic                 ready;
   ami_pkg::index_type   out_index;
   ami_pkg::value_type   out_value;
   logic                 singular;
   logic                 saturated;
   logic                 last_result;
   modport source (output valid, out_index, out_value, singular, saturated, last_result,
                   input ready);
   modport sink   (input valid, out_index, out_value, singular, saturated, last_result,
                   output ready);
endinterface

interface ami_csr_if;
   logic                 valid;
   logic                 ready;
   ami_pkg::shift_type   data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/affine_matrix_inverse_4x4_unit.sv =====
// affine 4x4 matrix inverse by adjugate, one shared multiplier under a sequencer
// depends on ami_pkg, ami_ifs and affine_matrix_inverse_4x4_unit_macros.svh
//
// channel    dir  payload
// req_chan   in   element_index, element_value, last_element
// rsp_chan   out  out_index, out_value, singular, saturated, last_result
// csr_chan   in   tolerance_shift (6 bits)
//
// a beat with last_element starts the inversion
// each multiply runs setup, partial products on the shared 32x32 unit, finish and post
// inversion: 6 triples x2 muls, 9 entries x3 muls, 3 rows x4 muls,
// plus det, check, the restoring divider and recip; a singular matrix stops after check
// 16 result beats (one if singular), each held until rsp ready; no load meanwhile
// reset is synchronous, clears the matrix store and sets tolerance_shift to 20
module affine_matrix_inverse_4x4_unit (
   input logic clock,
   input logic reset,
   ami_req_if.sink   req_chan,
   ami_rsp_if.source rsp_chan,
   ami_csr_if.sink   csr_chan
);
   import ami_pkg::*;
   `include "affine_matrix_inverse_4x4_unit_macros.svh"

   state_type    state_ff, state_in;
   phase_type    phase_ff, phase_in;
   logic [3:0]   item_ff, item_in;
   logic [1:0]   sub_ff, sub_in;
   shift_type    tol_ff, tol_in;
   value_type    mat_ff [12];
   value_type    mat_in [12];
   value_type    inv_ff [12];
   value_type    inv_in [12];
   logic [11:0]  flag_ff, flag_in;
   wide_type     pos_ff, pos_in, neg_ff, neg_in, det_ff, det_in;
   wide_type     tmp_ff, tmp_in, recip_ff, recip_in, res_ff, res_in;
   logic         rsat_ff, rsat_in, cflag_ff, cflag_in;
   logic [63:0]  ma_ff, ma_in, mb_ff, mb_in;
   logic         pneg_ff, pneg_in, limv_ff, limv_in;
   shsel_type    shsel_ff, shsel_in;
   logic [127:0] acc_ff, acc_in;
   logic [1:0]   part_ff, part_in;
   logic [64:0]  rem_ff, rem_in;
   logic [63:0]  num_ff, num_in, den_ff, den_in, quo_ff, quo_in;
   logic [5:0]   dcnt_ff, dcnt_in;
   logic [3:0]   emit_ff, emit_in;
   logic         sing_ff, sing_in;

   logic         req_fire, rsp_fire, rsp_last, sing_now;
   logic [63:0]  ud, spread;
   logic [127:0] tol_shifted;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign rsp_last = sing_ff || (emit_ff == 4'd15);

   assign ud          = det_ff[63] ? (64'd0 - det_ff) : det_ff;
   assign spread      = pos_ff - neg_ff;
   assign tol_shifted = {64'd0, ud} << tol_ff;
   assign sing_now    = (det_ff == '0) ||
                        ((tol_shifted[127:64] == '0) && (tol_shifted[63:0] < spread));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_chan.last_element) state_in = ST_SETUP;
         end
         ST_SETUP: state_in = ST_MUL;
         ST_MUL: begin
            if (part_ff == 2'd3) state_in = ST_FIN;
         end
         ST_FIN: state_in = ST_POST;
         ST_POST: begin
            priority if (phase_ff == PH_TRI && sub_ff == 2'd1 && item_ff == 4'd5) begin
               state_in = ST_DET;
            end else if (phase_ff == PH_TRN && sub_ff == 2'd3 && item_ff == 4'd2) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_SETUP;
            end
         end
         ST_DET: state_in = ST_CHECK;
         ST_CHECK: state_in = sing_now ? ST_EMIT : ST_DIV;
         ST_DIV: begin
            if (dcnt_ff == 6'd63) state_in = ST_RECIP;
         end
         ST_RECIP: state_in = ST_SETUP;
         ST_EMIT: begin
            if (rsp_fire && rsp_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // channel outputs
   always_comb begin
      req_chan.ready       = (state_ff == ST_IDLE);
      csr_chan.ready       = 1'b1;
      rsp_chan.valid       = (state_ff == ST_EMIT);
      rsp_chan.out_index   = sing_ff ? 4'd0 : emit_ff;
      rsp_chan.singular    = sing_ff;
      rsp_chan.last_result = rsp_last;
      priority if (sing_ff) begin
         rsp_chan.out_value = '0;
         rsp_chan.saturated = 1'b0;
      end else if (emit_ff < 4'd12) begin
         rsp_chan.out_value = inv_ff[emit_ff];
         rsp_chan.saturated = flag_ff[emit_ff];
      end else if (emit_ff == 4'd15) begin
         rsp_chan.out_value = ONE_VAL[VALUE_WIDTH-1:0];
         rsp_chan.saturated = ONE_SAT;
      end else begin
         rsp_chan.out_value = '0;
         rsp_chan.saturated = 1'b0;
      end
   end

   // datapath and sequencer counters
   always_comb begin
      tri_sel_type  ts;
      cof_sel_type  cs;
      wide_type     opa, opb;
      logic         flip;
      logic [63:0]  pp;
      logic [1:0]   psum;
      logic [127:0] rnd, shifted;
      logic [63:0]  maxmag, mag;
      logic         sat;
      logic [64:0]  sadd, rnext;

      phase_in = phase_ff;   item_in = item_ff;   sub_in = sub_ff;
      tol_in = tol_ff;       mat_in = mat_ff;     inv_in = inv_ff;
      flag_in = flag_ff;     pos_in = pos_ff;     neg_in = neg_ff;
      det_in = det_ff;       tmp_in = tmp_ff;     recip_in = recip_ff;
      res_in = res_ff;       rsat_in = rsat_ff;   cflag_in = cflag_ff;
      ma_in = ma_ff;         mb_in = mb_ff;       pneg_in = pneg_ff;
      limv_in = limv_ff;     shsel_in = shsel_ff; acc_in = acc_ff;
      part_in = part_ff;     rem_in = rem_ff;     num_in = num_ff;
      den_in = den_ff;       quo_in = quo_ff;     dcnt_in = dcnt_ff;
      emit_in = emit_ff;     sing_in = sing_ff;

      ts   = tri_sel(item_ff[2:0]);
      cs   = cof_sel(item_ff);
      opa  = '0;
      opb  = '0;
      flip = 1'b0;
      pp   = ma_ff[{part_ff[1], 5'd0} +: 32] * mb_ff[{part_ff[0], 5'd0} +: 32];
      psum = {1'b0, part_ff[1]} + {1'b0, part_ff[0]};
      rnd     = acc_ff;
      shifted = acc_ff;
      maxmag  = (limv_ff ? VAL_LIM : S64_MAX) + {63'd0, pneg_ff};
      sadd    = adds(tmp_ff, res_ff);
      rnext   = {rem_ff[63:0], num_ff[63]};

      if (csr_chan.valid) tol_in = csr_chan.data;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.element_index < 4'd12) begin
                  mat_in[req_chan.element_index] = req_chan.element_value;
               end
               if (req_chan.last_element) begin
                  pos_in   = '0;
                  neg_in   = '0;
                  phase_in = PH_TRI;
                  item_in  = '0;
                  sub_in   = '0;
               end
            end
         end
         ST_SETUP: begin
            shsel_in = SH_NONE;
            limv_in  = 1'b0;
            unique case (phase_ff)
               PH_TRI: begin
                  if (sub_ff == 2'd0) begin
                     opa = sx(mat_ff[ts.a]);
                     opb = sx(mat_ff[ts.b]);
                  end else begin
                     opa      = tmp_ff;
                     opb      = sx(mat_ff[ts.c]);
                     flip     = ts.flip;
                     shsel_in = SH_FRAC;
                  end
               end
               PH_COF: begin
                  unique case (sub_ff)
                     2'd0: begin
                        opa = sx(mat_ff[cs.a]);
                        opb = sx(mat_ff[cs.b]);
                     end
                     2'd1: begin
                        opa  = sx(mat_ff[cs.c]);
                        opb  = sx(mat_ff[cs.d]);
                        flip = 1'b1;
                     end
                     default: begin
                        opa      = tmp_ff;
                        opb      = recip_ff;
                        shsel_in = SH_RECIP;
                        limv_in  = 1'b1;
                     end
                  endcase
               end
               default: begin
                  if (sub_ff != 2'd3) begin
                     opa = sx(mat_ff[{sub_ff, 2'b11}]);
                     opb = sx(inv_ff[{item_ff[1:0], sub_ff}]);
                  end else begin
                     // translation = -(sum) rounded back to the value format
                     opa      = tmp_ff;
                     opb      = 64'sd1;
                     flip     = 1'b1;
                     shsel_in = SH_FRAC;
                     limv_in  = 1'b1;
                  end
               end
            endcase
            ma_in   = opa[63] ? (64'd0 - opa) : opa;
            mb_in   = opb[63] ? (64'd0 - opb) : opb;
            pneg_in = opa[63] ^ opb[63] ^ flip;
            acc_in  = '0;
            part_in = '0;
         end
         ST_MUL: begin
            acc_in  = acc_ff + ({64'd0, pp} << {psum, 5'd0});
            part_in = part_ff + 2'd1;
         end
         ST_FIN: begin
            unique case (shsel_ff)
               SH_FRAC: begin
                  rnd     = acc_ff + (128'd1 << (FRACTION_BITS - 1));
                  shifted = rnd >> FRACTION_BITS;
               end
               SH_RECIP: begin
                  rnd     = acc_ff + (128'd1 << (61 - FRACTION_BITS));
                  shifted = rnd >> (62 - FRACTION_BITS);
               end
               default: begin
                  rnd     = acc_ff;
                  shifted = acc_ff;
               end
            endcase
            sat     = (shifted[127:64] != '0) || (shifted[63:0] > maxmag);
            mag     = sat ? maxmag : shifted[63:0];
            res_in  = pneg_ff ? (64'd0 - mag) : mag;
            rsat_in = sat;
         end
         ST_POST: begin
            unique case (phase_ff)
               PH_TRI: begin
                  if (sub_ff == 2'd0) begin
                     tmp_in = res_ff;
                     sub_in = 2'd1;
                  end else begin
                     if (!res_ff[63]) begin
                        sadd   = adds(pos_ff, res_ff);
                        pos_in = sadd[63:0];
                     end else begin
                        sadd   = adds(neg_ff, res_ff);
                        neg_in = sadd[63:0];
                     end
                     sub_in  = 2'd0;
                     item_in = item_ff + 4'd1;
                  end
               end
               PH_COF: begin
                  unique case (sub_ff)
                     2'd0: begin
                        tmp_in   = res_ff;
                        cflag_in = rsat_ff;
                        sub_in   = 2'd1;
                     end
                     2'd1: begin
                        tmp_in   = sadd[63:0];
                        cflag_in = cflag_ff | rsat_ff | sadd[64];
                        sub_in   = 2'd2;
                     end
                     default: begin
                        inv_in[cof_elem(item_ff)]  = res_ff[VALUE_WIDTH-1:0];
                        flag_in[cof_elem(item_ff)] = cflag_ff | rsat_ff;
                        sub_in = 2'd0;
                        if (item_ff == 4'd8) begin
                           phase_in = PH_TRN;
                           item_in  = '0;
                        end else begin
                           item_in = item_ff + 4'd1;
                        end
                     end
                  endcase
               end
               default: begin
                  unique case (sub_ff)
                     2'd0: begin
                        tmp_in   = res_ff;
                        cflag_in = rsat_ff;
                     end
                     2'd3: begin
                        inv_in[{item_ff[1:0], 2'b11}]  = res_ff[VALUE_WIDTH-1:0];
                        flag_in[{item_ff[1:0], 2'b11}] = cflag_ff | rsat_ff;
                        item_in = item_ff + 4'd1;
                     end
                     default: begin
                        tmp_in   = sadd[63:0];
                        cflag_in = cflag_ff | rsat_ff | sadd[64];
                     end
                  endcase
                  sub_in = sub_ff + 2'd1;
               end
            endcase
            emit_in = '0;
            sing_in = 1'b0;
         end
         ST_DET: begin
            sadd   = adds(pos_ff, neg_ff);
            det_in = sadd[63:0];
         end
         ST_CHECK: begin
            emit_in = '0;
            sing_in = sing_now;
            den_in  = ud;
            num_in  = (64'd1 << 62) + (ud >> 1);
            rem_in  = '0;
            quo_in  = '0;
            dcnt_in = '0;
         end
         ST_DIV: begin
            // restoring division, one quotient bit per cycle
            if (rnext >= {1'b0, den_ff}) begin
               rem_in = rnext - {1'b0, den_ff};
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = rnext;
               quo_in = {quo_ff[62:0], 1'b0};
            end
            num_in  = {num_ff[62:0], 1'b0};
            dcnt_in = dcnt_ff + 6'd1;
         end
         ST_RECIP: begin
            recip_in = det_ff[63] ? (64'd0 - quo_ff) : quo_ff;
            phase_in = PH_COF;
            item_in  = '0;
            sub_in   = '0;
         end
         ST_EMIT: begin
            if (rsp_fire && !rsp_last) emit_in = emit_ff + 4'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tol_ff   <= TOL_RESET;
         for (int i = 0; i < 12; i++) mat_ff[i] <= '0;
         phase_ff <= PH_TRI;
         item_ff  <= '0;
         sub_ff   <= '0;
         part_ff  <= '0;
         dcnt_ff  <= '0;
         emit_ff  <= '0;
         sing_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         tol_ff   <= tol_in;
         mat_ff   <= mat_in;
         phase_ff <= phase_in;
         item_ff  <= item_in;
         sub_ff   <= sub_in;
         part_ff  <= part_in;
         dcnt_ff  <= dcnt_in;
         emit_ff  <= emit_in;
         sing_ff  <= sing_in;
      end
   end

   always_ff @(posedge clock) begin
      inv_ff   <= inv_in;
      flag_ff  <= flag_in;
      pos_ff   <= pos_in;
      neg_ff   <= neg_in;
      det_ff   <= det_in;
      tmp_ff   <= tmp_in;
      recip_ff <= recip_in;
      res_ff   <= res_in;
      rsat_ff  <= rsat_in;
      cflag_ff <= cflag_in;
      ma_ff    <= ma_in;
      mb_ff    <= mb_in;
      pneg_ff  <= pneg_in;
      limv_ff  <= limv_in;
      shsel_ff <= shsel_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      quo_ff   <= quo_in;
   end

   `AMI_ASSERT_IMP(a_no_load_while_emit, req_chan.ready, !rsp_chan.valid, "load during emit")
   `AMI_ASSERT_IMP(a_singular_single, rsp_chan.valid && rsp_chan.singular, rsp_chan.last_result && rsp_chan.out_index == 4'd0, "singular beat malformed")
   `AMI_ASSERT_NEXT(a_load_stays_ready, req_fire && !req_chan.last_element, req_chan.ready, "lost ready after load beat")
   `AMI_ASSERT_NEXT(a_div_runs_full, state_ff == ST_DIV && dcnt_ff != 6'd63, state_ff == ST_DIV, "divider cut short")

endmodule

// ===== sim/tb_affine_matrix_inverse_4x4_unit.sv =====
// testbench for affine_matrix_inverse_4x4_unit: loads directed and random affine matrices and checks
// every result beat against an inverse predicted in the testbench itself
// depends on ami_pkg, ami_ifs and the unit under test
module tb_affine_matrix_inverse_4x4_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import ami_pkg::*;

   localparam int  CYCLE_LIMIT = 1000000;
   localparam int  SETTLE      = 600;
   localparam int  LONG_HOLD   = 900;
   localparam logic signed [63:0] ONE_FX = 64'sd1 <<< FRACTION_BITS;

   typedef struct {
      index_type idx;
      value_type val;
      logic      last;
   } load_beat_t;

   typedef struct {
      index_type idx;
      value_type val;
      logic      sing;
      logic      sat;
      logic      last;
   } inv_beat_t;

   logic clock;
   logic reset;

   ami_req_if req_chan ();
   ami_rsp_if rsp_chan ();
   ami_csr_if csr_chan ();

   affine_matrix_inverse_4x4_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   load_beat_t  load_queue[$];
   inv_beat_t   inverse_queue[$];
   logic signed [63:0] matrix_copy[12];
   shift_type   tol_copy;
   int          errors;
   int          cycles;
   int          beats_seen;
   logic        send_jitter;
   logic        recv_jitter;
   logic        hold_done;
   int          hold_left;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // round(a*b / 2^sh) clipped to [-lim-1, lim]
   function automatic logic signed [63:0] mul_round(input logic signed [63:0] a,
         input logic signed [63:0] b, input int sh, input logic [63:0] lim,
         inout logic sat);
      logic         neg;
      logic [63:0]  ua, ub, maxmag;
      logic [127:0] p;
      neg = a[63] ^ b[63];
      ua = a[63] ? 64'd0 - a : a;
      ub = b[63] ? 64'd0 - b : b;
      p = {64'd0, ua} * {64'd0, ub};
      if (sh > 0) begin
         p = (p + (128'd1 << (sh - 1))) >> sh;
      end
      maxmag = neg ? lim + 64'd1 : lim;
      if (p > {64'd0, maxmag}) begin
         sat = 1'b1;
         p = {64'd0, maxmag};
      end
      return neg ? 64'd0 - p[63:0] : p[63:0];
   endfunction

   function automatic logic signed [63:0] add_clip(input logic signed [63:0] a,
         input logic signed [63:0] b, inout logic sat);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         sat = 1'b1;
         s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return s;
   endfunction

   function automatic logic signed [63:0] triple_prod(input logic signed [63:0] a,
         input logic signed [63:0] b, input logic signed [63:0] c);
      logic s;
      logic signed [63:0] p;
      s = 1'b0;
      p = mul_round(a, b, 0, S64_MAX, s);
      return mul_round(p, c, FRACTION_BITS, S64_MAX, s);
   endfunction

   function automatic logic signed [63:0] adj_entry(input int a, input int b, input int c,
         input int d, inout logic sat);
      logic signed [63:0] p, q;
      p = mul_round(matrix_copy[a], matrix_copy[b], 0, S64_MAX, sat);
      q = mul_round(matrix_copy[c], -matrix_copy[d], 0, S64_MAX, sat);
      return add_clip(p, q, sat);
   endfunction

   function automatic void push_beat(input int idx, input logic signed [63:0] v,
         input logic sing, input logic sat, input logic last);
      inv_beat_t b;
      b.idx  = idx[3:0];
      b.val  = v[VALUE_WIDTH-1:0];
      b.sing = sing;
      b.sat  = sat;
      b.last = last;
      inverse_queue.push_back(b);
   endfunction

   // store one load beat and, on the last mark, queue the inverse it yields
   function automatic void predict_inverse(input load_beat_t ld);
      logic signed [63:0] tp[6];
      logic signed [63:0] adj[9];
      logic signed [63:0] inv[12];
      logic signed [63:0] pos, neg, det, sum, p, one;
      logic [63:0] ud, spread, q, recip;
      logic        fl[12];
      logic        s;
      int          e;
      if (ld.idx < 12) begin
         matrix_copy[ld.idx] = {{(64-VALUE_WIDTH){ld.val[VALUE_WIDTH-1]}}, ld.val};
      end
      if (!ld.last) begin
         return;
      end
      tp[0] = triple_prod(matrix_copy[0], matrix_copy[5], matrix_copy[10]);
      tp[1] = triple_prod(matrix_copy[1], matrix_copy[6], matrix_copy[8]);
      tp[2] = triple_prod(matrix_copy[2], matrix_copy[4], matrix_copy[9]);
      tp[3] = triple_prod(matrix_copy[2], matrix_copy[5], -matrix_copy[8]);
      tp[4] = triple_prod(matrix_copy[1], matrix_copy[4], -matrix_copy[10]);
      tp[5] = triple_prod(matrix_copy[0], matrix_copy[6], -matrix_copy[9]);
      s = 1'b0;
      pos = 0;
      neg = 0;
      for (int i = 0; i < 6; i++) begin
         if (!tp[i][63]) pos = add_clip(pos, tp[i], s);
         else neg = add_clip(neg, tp[i], s);
      end
      det = add_clip(pos, neg, s);
      ud = det[63] ? 64'd0 - det : det;
      spread = pos + (64'd0 - neg);
      if (det == 0 || (ud <= ({64{1'b1}} >> tol_copy) && (ud << tol_copy) < spread)) begin
         push_beat(0, 0, 1'b1, 1'b0, 1'b1);
         return;
      end
      q = ((64'd1 << 62) + (ud >> 1)) / ud;
      recip = det[63] ? 64'd0 - q : q;
      foreach (fl[i]) fl[i] = 1'b0;
      adj[0] = adj_entry(5, 10, 6, 9, fl[0]);
      adj[1] = adj_entry(2, 9, 1, 10, fl[1]);
      adj[2] = adj_entry(1, 6, 2, 5, fl[2]);
      adj[3] = adj_entry(6, 8, 4, 10, fl[4]);
      adj[4] = adj_entry(0, 10, 2, 8, fl[5]);
      adj[5] = adj_entry(2, 4, 0, 6, fl[6]);
      adj[6] = adj_entry(4, 9, 5, 8, fl[8]);
      adj[7] = adj_entry(1, 8, 0, 9, fl[9]);
      adj[8] = adj_entry(0, 5, 1, 4, fl[10]);
      for (int r = 0; r < 3; r++) begin
         sum = 0;
         for (int c = 0; c < 3; c++) begin
            e = r * 4 + c;
            inv[e] = mul_round(adj[r*3+c], recip, 62 - FRACTION_BITS, VAL_LIM, fl[e]);
         end
         for (int c = 0; c < 3; c++) begin
            p = mul_round(matrix_copy[c*4+3], inv[r*4+c], 0, S64_MAX, fl[r*4+3]);
            sum = add_clip(sum, p, fl[r*4+3]);
         end
         inv[r*4+3] = mul_round(sum, -64'sd1, FRACTION_BITS, VAL_LIM, fl[r*4+3]);
      end
      for (int i = 0; i < 12; i++) push_beat(i, inv[i], 1'b0, fl[i], 1'b0);
      for (int i = 12; i < 15; i++) push_beat(i, 0, 1'b0, 1'b0, 1'b0);
      s = 1'b0;
      one = mul_round(1, 1, 0, VAL_LIM, s);
      one = mul_round(one, ONE_FX, 0, VAL_LIM, s);
      push_beat(15, one, 1'b0, s, 1'b1);
   endfunction

   // driver: one beat per handshake, random gaps while jitter is on
   always @(posedge clock) begin
      logic next_valid;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         next_valid = req_chan.valid;
         if (req_chan.valid && req_chan.ready) begin
            predict_inverse(load_queue.pop_front());
            next_valid = 1'b0;
         end
         if (!next_valid && load_queue.size() > 0
               && !(send_jitter && $urandom_range(0, 99) < 12)) begin
            next_valid = 1'b1;
            req_chan.element_index <= load_queue[0].idx;
            req_chan.element_value <= load_queue[0].val;
            req_chan.last_element  <= load_queue[0].last;
         end
         req_chan.valid <= next_valid;
      end
   end

   // monitor: compare each result beat with the oldest prediction
   always @(posedge clock) begin
      inv_beat_t x;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            beats_seen++;
            if (inverse_queue.size() == 0) begin
               errors++;
               $display("%0t unexpected beat idx=%0d val=%0h", $time,
                        rsp_chan.out_index, rsp_chan.out_value);
            end else begin
               x = inverse_queue.pop_front();
               if (rsp_chan.out_index !== x.idx || rsp_chan.out_value !== x.val
                     || rsp_chan.singular !== x.sing || rsp_chan.saturated !== x.sat
                     || rsp_chan.last_result !== x.last) begin
                  errors++;
                  $display("%0t expected idx=%0d val=%0h sing=%0b sat=%0b last=%0b", $time,
                           x.idx, x.val, x.sing, x.sat, x.last);
                  $display("%0t actual   idx=%0d val=%0h sing=%0b sat=%0b last=%0b", $time,
                           rsp_chan.out_index, rsp_chan.out_value, rsp_chan.singular,
                           rsp_chan.saturated, rsp_chan.last_result);
               end
            end
         end
         // one long hold-off while loads are still pending so the unit backs up
         if (!hold_done && beats_seen >= 60 && load_queue.size() > 2) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= !(recv_jitter && $urandom_range(0, 99) < 12);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic add_load(input int idx, input logic signed [31:0] v, input logic last);
      load_beat_t b;
      b.idx  = idx[3:0];
      b.val  = v;
      b.last = last;
      load_queue.push_back(b);
   endtask

   function automatic logic signed [31:0] fx_small();
      return $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
   endfunction

   function automatic logic signed [31:0] fx_any();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return 32'sh7fffffff;
      if (k == 1) return 32'sh80000000;
      if (k == 2) return 0;
      if (k < 6) return $urandom();
      return fx_small();
   endfunction

   // random matrix sequence; returns the number of beats queued
   task automatic add_matrix(output int n);
      int kind, order[12], tmp, j, cnt;
      logic signed [31:0] row[4];
      kind = $urandom_range(0, 99);
      n = 0;
      foreach (order[i]) order[i] = i;
      for (int i = 11; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      if (kind < 65) begin
         for (int i = 0; i < 11; i++) add_load(order[i], fx_small(), 1'b0);
         add_load(order[11], fx_small(), 1'b1);
         n = 12;
      end else if (kind < 77) begin
         // a row and that row scaled by two plus a small offset give a near-zero determinant
         for (int c = 0; c < 4; c++) row[c] = fx_small() >>> 2;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
               add_load(r * 4 + c, (r == 2) ? row[c] * 2 + $urandom_range(0, 3)
                        : (r == 1 ? row[c] : fx_small()), (r == 2 && c == 3));
            end
         end
         n = 12;
      end else if (kind < 89) begin
         // partial reload, sometimes marking last on an ignored bottom-row index
         cnt = $urandom_range(1, 5);
         for (int i = 0; i < cnt; i++) add_load(order[i], fx_small(), 1'b0);
         if ($urandom_range(0, 1)) add_load($urandom_range(12, 15), fx_any(), 1'b1);
         else add_load(order[cnt], fx_small(), 1'b1);
         n = cnt + 1;
      end else begin
         cnt = $urandom_range(1, 14);
         for (int i = 0; i < cnt; i++) begin
            add_load($urandom_range(0, 15), fx_any(), i == cnt - 1);
         end
         n = cnt;
      end
   endtask

   task automatic drain();
      do @(posedge clock);
      while (load_queue.size() > 0 || req_chan.valid || inverse_queue.size() > 0);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_tolerance(input shift_type v);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= v;
      do @(posedge clock);
      while (!(csr_chan.valid && csr_chan.ready));
      tol_copy = v;
      csr_chan.valid <= 1'b0;
   endtask

   initial begin
      int n, total;
      shift_type tol_plan[5];
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.element_index = '0;
      req_chan.element_value = '0;
      req_chan.last_element = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.data = '0;
      errors = 0;
      cycles = 0;
      beats_seen = 0;
      hold_done = 1'b0;
      hold_left = 0;
      send_jitter = 1'b1;
      recv_jitter = 1'b1;
      tol_copy = TOL_RESET;
      foreach (matrix_copy[i]) matrix_copy[i] = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: cleared store is singular, identity with translation, extremes
      add_load(15, 32'sh7fffffff, 1'b1);
      for (int i = 0; i < 12; i++) begin
         add_load(i, (i % 5 == 0) ? 32'sh10000 : (i % 4 == 3 ? 32'sh30000 : 0), i == 11);
      end
      add_load(3, 32'sh80000000, 1'b0);
      add_load(0, 32'sh7fffffff, 1'b0);
      add_load(5, 32'sh80000000, 1'b1);
      add_load(10, 32'sh00000001, 1'b1);
      add_load(13, 32'sh0, 1'b0);
      add_load(0, 32'sh00000100, 1'b1);
      drain();

      tol_plan[0] = 6'd0;
      tol_plan[1] = 6'd63;
      tol_plan[2] = TOL_RESET;
      tol_plan[3] = shift_type'($urandom_range(1, 62));
      tol_plan[4] = shift_type'($urandom_range(0, 8));
      total = 0;
      for (int ph = 0; ph < 5; ph++) begin
         write_tolerance(tol_plan[ph]);
         // phase two runs with no idling on either side
         send_jitter = (ph != 2);
         recv_jitter = (ph != 2);
         while (total < (ph + 1) * 64) begin
            add_matrix(n);
            total += n;
         end
         drain();
      end

      repeat (SETTLE) @(posedge clock);
      if (errors == 0 && inverse_queue.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== affine_matrix_inverse_4x4_unit.f =====
+incdir+rtl
rtl/ami_pkg.sv
rtl/ami_ifs.sv
rtl/affine_matrix_inverse_4x4_unit.sv
sim/tb_affine_matrix_inverse_4x4_unit.sv
